// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled at the clock, off during reset
`define RSCRF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("property failed");

// Same-cycle implication
`define RSCRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication
`define RSCRF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: rtl/rscrf_pkg.sv
// ---------------------------------------------------------------------------
// rscrf_pkg
// Constants, command codes and shared types of the SPI command register file.
// ---------------------------------------------------------------------------
package rscrf_pkg;

  localparam int MAX_PAYLOAD_DEF   = 32;
  localparam int ADDRESS_BYTES_DEF = 4;
  localparam int CONFIG_BYTES      = 10;

  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;

  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_SPI   = 2'd1;
  localparam logic [1:0] KIND_RADIO = 2'd2;

  localparam logic [7:0] CMD_HI_MASK      = 8'hF0;
  localparam logic [7:0] CMD_LO_MASK      = 8'h0F;
  localparam logic [7:0] CMD_W_CONFIG     = 8'h00;
  localparam logic [7:0] CMD_R_CONFIG     = 8'h10;
  localparam logic [7:0] CMD_W_TX_PAYLOAD = 8'h20;
  localparam logic [7:0] CMD_R_TX_PAYLOAD = 8'h21;
  localparam logic [7:0] CMD_W_TX_ADDRESS = 8'h22;
  localparam logic [7:0] CMD_R_TX_ADDRESS = 8'h23;
  localparam logic [7:0] CMD_R_RX_PAYLOAD = 8'h24;
  localparam logic [7:0] CMD_NOP          = 8'hFF;

  localparam logic [7:0] ADDR_DEFAULT = 8'hE7;
  localparam logic [5:0] PTR_MAX      = 6'd63;

  localparam logic [7:0] CFG_DEFAULTS [CONFIG_BYTES] = '{
    8'h6C, 8'h00, 8'h44, 8'h20, 8'h20, 8'hE7, 8'hE7, 8'hE7, 8'hE7, 8'hE7
  };

  typedef struct packed {
    logic load_item;
    logic exec;
  } rscrf_ctrl_t;

  function automatic logic [5:0] sat_width(input logic [7:0] v, input logic [5:0] max_w);
    logic [5:0] r;
    if (v == 8'd0) begin
      r = 6'd1;
    end else if (v > {2'b00, max_w}) begin
      r = max_w;
    end else begin
      r = v[5:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/rscrf_ctrl.sv
// ---------------------------------------------------------------------------
// rscrf_ctrl
// Sequencer: captures one request, then executes it once the result
// register is free, and tracks result validity.
// ---------------------------------------------------------------------------
module rscrf_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output rscrf_pkg::rscrf_ctrl_t ctrl
);
  import rscrf_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    ctrl.load_item = 1'b0;
    ctrl.exec      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctrl.load_item = 1'b1;
          state_nxt      = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          ctrl.exec = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = ctrl.exec ? 1'b1 : (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/rscrf_dp.sv
// ---------------------------------------------------------------------------
// rscrf_dp
// Datapath: request capture, command decode, configuration, payload and
// address stores, receive fill logic and the result register.
// ---------------------------------------------------------------------------
module rscrf_dp #(
  parameter int MAX_PAYLOAD   = rscrf_pkg::MAX_PAYLOAD_DEF,
  parameter int ADDRESS_BYTES = rscrf_pkg::ADDRESS_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rscrf_pkg::rscrf_ctrl_t             ctrl,
  input  logic [rscrf_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [rscrf_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic [rscrf_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import rscrf_pkg::*;

  localparam int PW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int AW = (ADDRESS_BYTES > 1) ? $clog2(ADDRESS_BYTES) : 1;
  localparam logic [5:0] MAX_PW = 6'(MAX_PAYLOAD);
  localparam logic [5:0] ADDR_N = 6'(ADDRESS_BYTES);
  localparam logic [5:0] CFG_N  = 6'(CONFIG_BYTES);

  logic [1:0]  kind_r;
  logic [7:0]  byte_r;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [5:0]  fp_r, fp_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic        ready_r, ready_nxt;
  logic [7:0]  cfg_r   [CONFIG_BYTES];
  logic [7:0]  cfg_v   [CONFIG_BYTES];
  logic [7:0]  txp_r   [MAX_PAYLOAD];
  logic [7:0]  rxp_r   [MAX_PAYLOAD];
  logic [7:0]  txa_r   [ADDRESS_BYTES];
  logic        cfg_we, txp_we, txa_we, rxp_we;
  logic [3:0]  cfg_idx;
  logic [PW-1:0] pay_idx, fill_idx;
  logic [AW-1:0] addr_idx;
  logic [7:0]  miso;
  logic        known;
  logic [5:0]  rx_w, fill_inc;
  logic [OUT_TDATA_W-1:0] out_r;

  assign cfg_idx  = fp_r[3:0];
  assign pay_idx  = fp_r[PW-1:0];
  assign addr_idx = fp_r[AW-1:0];
  assign fill_idx = fill_r[PW-1:0];
  assign rx_w     = sat_width(cfg_r[3], MAX_PW);
  assign out_tdata = out_r;

  always_comb begin
    cmd_nxt   = cmd_r;
    fp_nxt    = fp_r;
    fill_nxt  = fill_r;
    ready_nxt = ready_r;
    cfg_we    = 1'b0;
    txp_we    = 1'b0;
    txa_we    = 1'b0;
    rxp_we    = 1'b0;
    miso      = 8'd0;
    known     = 1'b1;
    fill_inc  = (fill_r < PTR_MAX) ? fill_r + 6'd1 : PTR_MAX;
    case (kind_r)
      KIND_CMD: begin
        cmd_nxt = byte_r;
        if ((byte_r & CMD_HI_MASK) == CMD_W_CONFIG ||
            (byte_r & CMD_HI_MASK) == CMD_R_CONFIG) begin
          fp_nxt = 6'(byte_r & CMD_LO_MASK);
        end else begin
          fp_nxt = 6'd0;
        end
        if (byte_r == CMD_R_RX_PAYLOAD) begin
          ready_nxt = 1'b0;
          fill_nxt  = 6'd0;
        end
      end
      KIND_SPI: begin
        if ((cmd_r & CMD_HI_MASK) == CMD_W_CONFIG) begin
          cfg_we = (fp_r < CFG_N);
        end else if ((cmd_r & CMD_HI_MASK) == CMD_R_CONFIG) begin
          if (fp_r < CFG_N) miso = cfg_r[cfg_idx];
        end else if (cmd_r == CMD_W_TX_PAYLOAD) begin
          txp_we = (fp_r < MAX_PW);
        end else if (cmd_r == CMD_R_TX_PAYLOAD) begin
          if (fp_r < MAX_PW) miso = txp_r[pay_idx];
        end else if (cmd_r == CMD_W_TX_ADDRESS) begin
          txa_we = (fp_r < ADDR_N);
        end else if (cmd_r == CMD_R_TX_ADDRESS) begin
          if (fp_r < ADDR_N) miso = txa_r[addr_idx];
        end else if (cmd_r == CMD_R_RX_PAYLOAD) begin
          if (fp_r < MAX_PW) miso = rxp_r[pay_idx];
        end else begin
          known = 1'b0;
        end
        if (known && fp_r < PTR_MAX) fp_nxt = fp_r + 6'd1;
      end
      KIND_RADIO: begin
        if (!ready_r) begin
          rxp_we   = (fill_r < MAX_PW);
          fill_nxt = fill_inc;
          if (fill_inc >= rx_w) begin
            ready_nxt = 1'b1;
            fill_nxt  = 6'd0;
          end
        end
      end
      default: known = 1'b0;
    endcase
    for (int i = 0; i < CONFIG_BYTES; i++) begin
      cfg_v[i] = (cfg_we && cfg_idx == 4'(i)) ? byte_r : cfg_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      kind_r <= in_tuser;
      byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= CMD_NOP;
      fp_r    <= 6'd0;
      fill_r  <= 6'd0;
      ready_r <= 1'b0;
      for (int i = 0; i < CONFIG_BYTES; i++) cfg_r[i] <= CFG_DEFAULTS[i];
      for (int i = 0; i < MAX_PAYLOAD; i++) begin
        txp_r[i] <= 8'd0;
        rxp_r[i] <= 8'd0;
      end
      for (int i = 0; i < ADDRESS_BYTES; i++) txa_r[i] <= ADDR_DEFAULT;
    end else if (ctrl.exec) begin
      cmd_r   <= cmd_nxt;
      fp_r    <= fp_nxt;
      fill_r  <= fill_nxt;
      ready_r <= ready_nxt;
      for (int i = 0; i < CONFIG_BYTES; i++) cfg_r[i] <= cfg_v[i];
      if (txp_we) txp_r[pay_idx]  <= byte_r;
      if (txa_we) txa_r[addr_idx] <= byte_r;
      if (rxp_we) rxp_r[fill_idx] <= byte_r;
    end
  end

  // load result from the post-update state
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      out_r <= {5'd0,
                cfg_v[9][7:6],
                sat_width(cfg_v[4], MAX_PW),
                sat_width(cfg_v[3], MAX_PW),
                cfg_v[2][6:4],
                cfg_v[2][2:0],
                cfg_v[1][5],
                cfg_v[1][4],
                cfg_v[1][3:2],
                cfg_v[1][1],
                cfg_v[1][0], cfg_v[0],
                ready_nxt,
                miso};
    end
  end

endmodule

// File: rtl/radio_spi_command_register_file.sv
// ---------------------------------------------------------------------------
// radio_spi_command_register_file
// Chip-side SPI command interface and register file of a sub-GHz radio.
// ---------------------------------------------------------------------------
// Input channel: in_tuser carries the item kind (command byte, following SPI
// byte, radio received byte), in_tdata the byte. Output channel: one result
// per request, holding the SPI read-back byte, data_ready and the decoded
// configuration fields after the request has been applied.
// A request is captured in the cycle it is accepted and executed once the
// result register is free, which loads the result register and raises
// out_tvalid. The capture/execute sequencer around the single register-file
// access takes a new request only after the last one has been executed.
// A new request is accepted while a result still waits; its execution holds
// until the result register is taken, and in_tready stays low meanwhile.
// Reset (rst_n low, synchronous) loads the configuration defaults, clears
// the payload stores, sets the transmit address to E7, the current command
// to NOP and empties the result register. No clearing pass is needed.
// ---------------------------------------------------------------------------
module radio_spi_command_register_file #(
  parameter int MAX_PAYLOAD   = rscrf_pkg::MAX_PAYLOAD_DEF,
  parameter int ADDRESS_BYTES = rscrf_pkg::ADDRESS_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rscrf_pkg::IN_TDATA_W-1:0]   in_tdata,  // [7:0] byte_value
  input  logic [rscrf_pkg::IN_TUSER_W-1:0]   in_tuser,  // [1:0] kind
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] miso_byte, [8] data_ready, [17:9] channel_number, [18] band_select,
  // [20:19] tx_power_level, [21] rx_low_current, [22] retry_enable,
  // [25:23] rx_address_width, [28:26] tx_address_width,
  // [34:29] rx_payload_width, [40:35] tx_payload_width, [42:41] crc_mode
  output logic [rscrf_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import rscrf_pkg::*;

  rscrf_ctrl_t ctrl;

  rscrf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctrl       (ctrl)
  );

  rscrf_dp #(
    .MAX_PAYLOAD   (MAX_PAYLOAD),
    .ADDRESS_BYTES (ADDRESS_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata)
  );

`include "assert_macros.svh"

  `RSCRF_ASSERT(a_cmd_excl, clk, rst_n, !(ctrl.exec && ctrl.load_item))
  `RSCRF_ASSERT_IMP(a_exec_free, clk, rst_n, ctrl.exec, !out_tvalid || out_tready)
  `RSCRF_ASSERT_NXT(a_exec_loads, clk, rst_n, ctrl.exec, out_tvalid)
  `RSCRF_ASSERT_NXT(a_accept_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)

endmodule
